>>> hw/rtl/gbte_pkg.sv
// ---------------------------------------------------------------------------
// gbte_pkg: shared types and constants for the gap buffer text editor
// Field widths, item kinds, status codes and the result record.
// ---------------------------------------------------------------------------
package gbte_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 11;
  localparam int LEN_W    = 11;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int TLEN_W   = 11;

  localparam int IN_TDATA_W  = 32;  // 2 + 11 + 11 + 8
  localparam int OUT_TDATA_W = 24;  // 2 + 8 + 11, padded to bytes

  typedef enum logic [KIND_W-1:0] {
    K_INSERT = 2'd0,
    K_DELETE = 2'd1,
    K_READ   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BEYOND  = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   read_data;
    logic [TLEN_W-1:0]   text_length;
  } res_t;

endpackage

>>> hw/rtl/gap_buffer_text_editor.sv
// ---------------------------------------------------------------------------
// gap_buffer_text_editor: byte text store with one movable gap
// Insert, delete and read items at logical positions, one result each.
// ---------------------------------------------------------------------------
//  - in_* channel: one transfer is one edit item (insert, delete or read).
//  - out_* channel: one transfer per item, status, read byte and the text
//    length after the item.
//  - An item is taken only while the sequencer is idle; it then owns the
//    block until its result is handed to the output register.
//  - Per item: a check step; reads, rejects and the unused kind then present
//    their result, while inserts and deletes first walk the gap, one registered
//    RAM read and one write per byte moved, and then apply the edit.
//  - A new item is not taken until the sequencer is back in idle.
//  - The result sits in an output register; the next item is accepted while
//    it waits. If out_tready stays low, the following item completes and then
//    holds the sequencer until the register drains.
//  - Reset (rst_n low, synchronous) empties the text: gap at position 0,
//    gap length CAPACITY. Store contents are not cleared; no reachable read
//    sees an unwritten byte.
// ---------------------------------------------------------------------------
module gap_buffer_text_editor import gbte_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] kind, [12:2] position, [23:13] length, [31:24] data_byte
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] status, [9:2] read_data, [20:10] text_length, [23:21] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(CAPACITY);

  logic              res_valid, res_ready;
  res_t              res;
  res_t              out_res_r;
  logic              out_valid_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  gbte_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tdata[1:0]),
    .req_pos   (in_tdata[12:2]),
    .req_len   (in_tdata[23:13]),
    .req_byte  (in_tdata[31:24]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // text store
  gbte_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: frees the sequencer as soon as the result is parked
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.text_length, out_res_r.read_data,
                       out_res_r.status};

endmodule

>>> hw/rtl/gbte_ram.sv
// ---------------------------------------------------------------------------
// gbte_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered, held when idle.
// ---------------------------------------------------------------------------
module gbte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/gbte_ctrl.sv
// ---------------------------------------------------------------------------
// gbte_ctrl: gap buffer sequencer
// Checks an item, walks the gap for inserts and deletes one byte at a time
// through a shared address adder, then applies the edit and presents one result.
// ---------------------------------------------------------------------------
module gbte_ctrl import gbte_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              rst_n,
  // item request
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [KIND_W-1:0] req_kind,
  input  logic [POS_W-1:0]  req_pos,
  input  logic [LEN_W-1:0]  req_len,
  input  logic [DATA_W-1:0] req_byte,
  // result
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  // text store
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MOVE  = 6'b000100,
    S_WR    = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [XW-1:0]     pos_r;
  logic [XW-1:0]     len_r, len_nxt;
  logic [DATA_W-1:0] byte_r;
  status_t           status_r, status_nxt;
  logic              left_r, left_nxt;
  logic [CW-1:0]     gap_start_r, gap_start_nxt;
  logic [CW-1:0]     gap_len_r, gap_len_nxt;
  logic [CW-1:0]     held_r, held_nxt;

  logic [XW-1:0]     held_x, gap_len_x, need_x, rem_x;
  logic [CW-1:0]     pos_c;
  logic [CW-1:0]     opa, opb, sum;

  assign held_x    = XW'(held_r);
  assign gap_len_x = XW'(gap_len_r);
  assign need_x    = (len_r == '0) ? XW'(1) : len_r;
  assign rem_x     = held_x - pos_r;
  assign pos_c     = pos_r[CW-1:0];

  // shared address adder
  always_comb begin
    opa = gap_start_r;
    opb = gap_len_r;
    if (state_r == S_CHECK) begin
      opa = pos_c;
    end else if (state_r == S_MOVE && pos_c < gap_start_r) begin
      opb = '1;
    end else if (state_r == S_WR && !left_r) begin
      opb = CW'(1);
    end
  end
  assign sum = opa + opb;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    status_nxt    = status_r;
    left_nxt      = left_r;
    gap_start_nxt = gap_start_r;
    gap_len_nxt   = gap_len_r;
    held_nxt      = held_r;
    ram_we        = 1'b0;
    ram_waddr     = gap_start_r[AW-1:0];
    ram_wdata     = byte_r;
    ram_re        = 1'b0;
    ram_raddr     = sum[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          state_nxt = S_CHECK;
          len_nxt   = XW'(req_len);
        end
      end
      S_CHECK: begin
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        case (kind_r)
          K_INSERT: begin
            if (pos_r > held_x) begin
              status_nxt = ST_BEYOND;
            end else if (need_x > gap_len_x) begin
              status_nxt = ST_NOSPACE;
            end else begin
              state_nxt = S_MOVE;
            end
          end
          K_DELETE: begin
            if (pos_r > held_x) begin
              status_nxt = ST_BEYOND;
            end else begin
              if (len_r > rem_x) begin
                len_nxt = rem_x;
              end
              state_nxt = S_MOVE;
            end
          end
          K_READ: begin
            if (pos_r >= held_x) begin
              status_nxt = ST_BEYOND;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = (pos_c < gap_start_r) ? pos_c[AW-1:0] : sum[AW-1:0];
            end
          end
          default: ;
        endcase
      end
      S_MOVE: begin
        if (pos_c == gap_start_r) begin
          state_nxt = S_APPLY;
        end else begin
          // left: fetch byte just below the gap; right: first byte above it
          left_nxt  = pos_c < gap_start_r;
          ram_re    = 1'b1;
          state_nxt = S_WR;
          if (pos_c < gap_start_r) begin
            gap_start_nxt = sum;
          end
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (left_r) begin
          ram_waddr = sum[AW-1:0];
        end else begin
          gap_start_nxt = sum;
        end
        state_nxt = S_MOVE;
      end
      S_APPLY: begin
        if (kind_r == K_INSERT) begin
          ram_we        = 1'b1;
          gap_start_nxt = gap_start_r + CW'(1);
          gap_len_nxt   = gap_len_r - CW'(1);
          held_nxt      = held_r + CW'(1);
        end else begin
          gap_len_nxt = gap_len_r + len_r[CW-1:0];
          held_nxt    = held_r - len_r[CW-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gap_start_r <= '0;
      gap_len_r   <= CW'(CAPACITY);
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      gap_start_r <= gap_start_nxt;
      gap_len_r   <= gap_len_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req_valid) begin
      kind_r <= req_kind;
      pos_r  <= XW'(req_pos);
      byte_r <= req_byte;
    end
    len_r    <= len_nxt;
    status_r <= status_nxt;
    left_r   <= left_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.status      = status_r;
    res.read_data   = (kind_r == K_READ && status_r == ST_OK) ? ram_rdata : '0;
    res.text_length = held_x[TLEN_W-1:0];
  end

endmodule

>>> dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: gap buffer text editor
// Streams insert, delete and read edits into the block and checks every
// result transfer against a gap buffer predictor held in the bench.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gbte_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int TEXT_CAP   = CAPACITY_DEF;
  localparam int PHASE_EDITS = 450;          // random edits per idling phase
  localparam int LIMIT_CYCLES = 10_000_000;  // hang guard
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // unused kind, must be a no-op

  // One edit on in_tdata, lowest bits first: kind, position, length, data_byte
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
    logic [POS_W-1:0]  position;
    logic [KIND_W-1:0] kind;
  } edit_item_t;

  // One result on out_tdata, lowest bits first: status, read_data,
  // text_length, then zero padding up to the byte boundary
  typedef struct packed {
    logic [OUT_TDATA_W-STATUS_W-DATA_W-TLEN_W-1:0] pad;
    logic [TLEN_W-1:0]   text_length;
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
  } edit_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  gap_buffer_text_editor #(
    .CAPACITY (TEXT_CAP)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor: the text lives in a byte store with one gap. Logical
  // position p sits at address p before the gap and p + gap_len after it.
  // Unwritten bytes read as zero, though no legal sequence reaches one.
  // -------------------------------------------------------------------------
  bit [DATA_W-1:0] text_mem [TEXT_CAP];
  int gap_at     = 0;
  int gap_len    = TEXT_CAP;
  int text_bytes = 0;

  // Walk the gap to logical position p, shifting the bytes in between.
  // Moving left copies from the top down, moving right from the bottom up,
  // so overlapping spans are never clobbered.
  function automatic void move_gap(int p);
    if (p < gap_at) begin
      for (int i = gap_at - p - 1; i >= 0; i--)
        text_mem[p + gap_len + i] = text_mem[p + i];
    end else begin
      for (int i = 0; i < p - gap_at; i++)
        text_mem[gap_at + i] = text_mem[gap_at + gap_len + i];
    end
    gap_at = p;
  endfunction

  function automatic edit_result_t apply_edit(edit_item_t it);
    edit_result_t r;
    int p, n, need, addr;
    r = '0;
    p = int'(it.position);
    n = int'(it.length);
    case (it.kind)
      K_INSERT: begin
        // a zero run length still needs room for the byte itself
        need = (n == 0) ? 1 : n;
        if (p > text_bytes) begin
          r.status = ST_BEYOND;        // position is checked before space
        end else if (need > gap_len) begin
          r.status = ST_NOSPACE;
        end else begin
          move_gap(p);
          text_mem[gap_at] = it.data_byte;
          gap_at++;
          gap_len--;
          text_bytes++;
        end
      end
      K_DELETE: begin
        if (p > text_bytes) begin
          r.status = ST_BEYOND;
        end else begin
          // clamp to the tail; a clamped zero still moves the gap
          if (n > text_bytes - p) n = text_bytes - p;
          move_gap(p);
          gap_len += n;
          text_bytes -= n;
        end
      end
      K_READ: begin
        if (p >= text_bytes) begin
          r.status = ST_BEYOND;
        end else begin
          addr = (p < gap_at) ? p : p + gap_len;
          if (addr < TEXT_CAP) r.read_data = text_mem[addr];
        end
      end
      default: ;                       // spare kind: no change, status ok
    endcase
    r.text_length = TLEN_W'(text_bytes);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus planning. plan_len and cursor follow the text length and the
  // editing point as the queued edits will leave them, so that the random
  // part can keep most edits local and well formed.
  // -------------------------------------------------------------------------
  edit_item_t   pending_edits [$];
  edit_result_t awaited_results [$];
  int  plan_len = 0;
  int  cursor   = 0;
  bit  item_held = 1'b0;   // in_tvalid is up with an edit not yet taken
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  mismatches  = 0;

  function automatic void queue_edit(logic [KIND_W-1:0] k, int p, int n, logic [DATA_W-1:0] b);
    edit_item_t it;
    int need;
    it.kind      = k;
    it.position  = POS_W'(p);
    it.length    = LEN_W'(n);
    it.data_byte = b;
    pending_edits.push_back(it);
    need = (n == 0) ? 1 : n;
    if (k == K_INSERT && p <= plan_len && need <= TEXT_CAP - plan_len) begin
      plan_len++;
      cursor = p + 1;
    end else if (k == K_DELETE && p <= plan_len) begin
      plan_len -= (n < plan_len - p) ? n : plan_len - p;
      cursor = p;
    end
  endfunction

  // Editing point for the next edit: mostly where the last one left off,
  // sometimes up to four steps away, rarely a jump anywhere in the text
  function automatic int near_cursor();
    int r, c;
    r = $urandom_range(99);
    if (r < 2) c = $urandom_range(plan_len);
    else if (r < 80) c = cursor;
    else c = cursor + $urandom_range(8) - 4;
    if (c < 0) c = 0;
    if (c > plan_len) c = plan_len;
    return c;
  endfunction

  // -------------------------------------------------------------------------
  // Input driver: changes at the falling edge only. A new edit goes up once
  // the previous one has transferred, unless the sender idles this cycle.
  // Idle cycles carry junk on in_tdata.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!item_held) begin
      if (pending_edits.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tdata  <= pending_edits.pop_front();
        in_tvalid <= 1'b1;
        item_held = 1'b1;
      end else begin
        in_tdata  <= $urandom;
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure, also on the falling edge
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  // Input transfer: run the predictor and queue what the block must return
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      awaited_results.push_back(apply_edit(in_tdata));
      item_held = 1'b0;
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result transfer: compare field by field with the oldest expectation
  always @(posedge clk) begin
    edit_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result %h, expected none", $time, out_tdata);
      end else begin
        want = awaited_results.pop_front();
        check_field("status",      16'(want.status),      16'(got.status));
        check_field("read_data",   16'(want.read_data),   16'(got.read_data));
        check_field("text_length", 16'(want.text_length), 16'(got.text_length));
        check_field("padding",     16'(want.pad),         16'(got.pad));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: reset, then three idling phases (sender slow / receiver slow,
  // the reverse, then full rate). The first phase opens with directed edits.
  // The random part mostly types at the cursor so the text grows towards a
  // full store; after a while at full it trims back and grows again.
  // -------------------------------------------------------------------------
  initial begin
    int phase, r, m, n, ins_w, del_w, full_run;
    bit trimming;
    logic [DATA_W-1:0] b;
    full_run = 0;
    trimming = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 23;
          rx_idle_pct = 62;
        end
        1: begin
          tx_idle_pct = 62;
          rx_idle_pct = 23;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // empty text: everything beyond, zero-length delete at 0 is fine
        queue_edit(K_READ,   0,    0,    8'h00);
        queue_edit(K_DELETE, 0,    0,    8'h00);
        queue_edit(K_DELETE, 1,    1,    8'h00);
        queue_edit(K_INSERT, 1,    1,    8'hFF);
        // first byte with a zero run length, then append at the end
        queue_edit(K_INSERT, 0,    0,    8'h00);
        queue_edit(K_INSERT, 1,    1,    8'hFF);
        // run longer than the gap; then beyond text and too long at once
        queue_edit(K_INSERT, 0,    2047, 8'h11);
        queue_edit(K_INSERT, 2047, 2047, 8'h22);
        // insert in the middle: text is 00 A5 FF
        queue_edit(K_INSERT, 1,    3,    8'hA5);
        queue_edit(K_READ,   0,    0,    8'h00);
        queue_edit(K_READ,   1,    2047, 8'hFF);
        queue_edit(K_READ,   2,    0,    8'h00);
        queue_edit(K_READ,   3,    0,    8'h00);
        queue_edit(K_READ,   2047, 2047, 8'hFF);
        queue_edit(KIND_SPARE, 2047, 2047, 8'hFF);
        // run length exactly equal to the gap, then one more than it
        queue_edit(K_INSERT, 3,    TEXT_CAP - 3, 8'h5A);
        queue_edit(K_INSERT, 0,    TEXT_CAP - 3, 8'hC3);
        // plain delete, delete past the end, clamped to zero
        queue_edit(K_DELETE, 1,    2,    8'h00);
        queue_edit(K_DELETE, 1,    2047, 8'h00);
        queue_edit(K_DELETE, 1,    5,    8'h00);
        queue_edit(K_READ,   0,    0,    8'h00);
        // wipe everything, then a run as long as the whole store
        queue_edit(K_DELETE, 0,    TEXT_CAP, 8'h00);
        queue_edit(K_INSERT, 0,    TEXT_CAP, 8'h3C);
        queue_edit(K_READ,   0,    0,    8'h00);
      end

      repeat (PHASE_EDITS) begin
        r = $urandom_range(99);
        b = DATA_W'($urandom_range(255));
        if (plan_len == TEXT_CAP) full_run++;
        if (full_run > 40) begin
          trimming = 1'b1;
          full_run = 0;
        end
        if (trimming && plan_len < TEXT_CAP / 2) trimming = 1'b0;
        ins_w = trimming ? 40 : 88;
        del_w = trimming ? 80 : 90;

        if (r < ins_w) begin
          // run length mostly small; now and then any 11-bit value
          n = ($urandom_range(49) == 0) ? $urandom_range(2047) : $urandom_range(16);
          queue_edit(K_INSERT, near_cursor(), n, b);
        end else if (r < del_w) begin
          queue_edit(K_DELETE, near_cursor(),
                     trimming ? $urandom_range(64) : $urandom_range(2), b);
        end else if (r < 98) begin
          // reads do not move the gap, so anywhere in the text is cheap
          queue_edit(K_READ, $urandom_range(plan_len), $urandom_range(2047), b);
        end else begin
          case ($urandom_range(2))
            0: queue_edit(KIND_SPARE, $urandom_range(2047), $urandom_range(2047), b);
            1: queue_edit(KIND_W'($urandom_range(2)),
                          plan_len + 1 + $urandom_range(2046 - plan_len),
                          $urandom_range(2047), b);
            default: begin
              // delete near the end with any length: clamps at the tail
              m = (plan_len < 8) ? plan_len : 8;
              queue_edit(K_DELETE, plan_len - $urandom_range(m), $urandom_range(2047), b);
            end
          endcase
        end
      end

      // phase boundary: let every edit transfer and every result come back
      while (pending_edits.size() != 0 || item_held || awaited_results.size() != 0)
        @(negedge clk);
    end

    // a gap walk across the whole store is the longest the block can take
    repeat (2 * TEXT_CAP + 16) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/gbte_pkg.sv
hw/rtl/gbte_ram.sv
hw/rtl/gbte_ctrl.sv
hw/rtl/gap_buffer_text_editor.sv
dv/testbench.sv
